/* hdl/rtdct_pkg.sv */
package rtdct_pkg;

	localparam int RAW_W   = 16;
	localparam int CODE_W  = 15;
	localparam int REF_W   = 12;
	localparam int RQ_W    = 28;
	localparam int X_W     = 23;
	localparam int K1_W    = 28;
	localparam int PROD_W  = 56;
	localparam int ARG_W   = 53;
	localparam int ROOT_W  = 27;
	localparam int SQ_STG  = 27;
	localparam int ACC_W   = 42;
	localparam int TEMP_W  = 18;
	localparam int TDATA_W = 24;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [REF_W-1:0] REF_RESET = 12'd430;

	localparam logic [ARG_W:0]   ARG0_Q16  = 54'd8638803886096887;
	localparam logic [K1_W-1:0]  K1_PER_RQ = 28'd173160173;
	localparam logic [ROOT_W:0]  C0_Q8     = 28'd86625524;

	localparam logic signed [20:0] TEMP_MAX = 21'sd100000;
	localparam logic signed [20:0] TEMP_MIN = -21'sd25000;

	typedef logic [RQ_W-1:0] rq_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// horner coefficients, highest power first, q.24 centidegrees
	localparam acc_t POLY_Q24 [0:5] = '{
		42'sd8786991247,
		-42'sd12692494830,
		-42'sd16979977970,
		42'sd71080677957,
		42'sd477342665277,
		-42'sd406042181632
	};

	typedef struct packed {
		logic valid;
		rq_t  rq;
	} q_entry_t;

endpackage

/* hdl/rtdct_front.sv */
module rtdct_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rtdct_pkg::REF_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	input  logic [rtdct_pkg::RAW_W-1:0]   raw_word,
	output rtdct_pkg::q_entry_t           push
);

	logic [rtdct_pkg::REF_W-1:0] ref_q;
	logic [rtdct_pkg::CODE_W+rtdct_pkg::REF_W-1:0] scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= rtdct_pkg::REF_RESET;
		end else if (cfg_we) begin
			ref_q <= cfg_wdata;
		end
	end

	// drop the fault bit, resistance in q12.16 ohms
	assign scaled     = raw_word[rtdct_pkg::RAW_W-1:1] * ref_q;
	assign push.rq    = {scaled, 1'b0};
	assign push.valid = in_valid;

endmodule

/* hdl/rtdct_queue.sv */
module rtdct_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  rtdct_pkg::q_entry_t push,
	output logic                full,
	input  logic                pop,
	output rtdct_pkg::q_entry_t head
);

	rtdct_pkg::rq_t mem_q [0:rtdct_pkg::Q_DEPTH-1];
	logic [rtdct_pkg::Q_AW-1:0] wr_q, rd_q;
	logic [rtdct_pkg::Q_AW:0]   cnt_q;
	logic do_push, do_pop;

	assign full       = (cnt_q == rtdct_pkg::Q_AW'(0) + (rtdct_pkg::Q_AW+1)'(rtdct_pkg::Q_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.rq    = mem_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.rq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (rtdct_pkg::Q_AW+1)'(do_push) - (rtdct_pkg::Q_AW+1)'(do_pop);
		end
	end

endmodule

/* hdl/rtdct_sqrt.sv */
module rtdct_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rtdct_pkg::ARG_W-1:0]   arg,
	output logic [rtdct_pkg::ROOT_W-1:0]  root
);

	localparam int VW = rtdct_pkg::ARG_W;
	localparam int RW = rtdct_pkg::ARG_W + 1;

	logic [VW-1:0] v_s [0:rtdct_pkg::SQ_STG];
	logic [RW-1:0] r_s [0:rtdct_pkg::SQ_STG];

	assign v_s[0] = arg;
	assign r_s[0] = '0;

	// one result bit per stage, trial bit walks down two places each step
	for (genvar i = 0; i < rtdct_pkg::SQ_STG; i++) begin : g_stg
		localparam logic [RW:0] ONE = (RW+1)'(1) << (2 * (rtdct_pkg::SQ_STG - 1 - i));
		logic [RW:0] trial;
		logic        take;
		logic [VW-1:0] v_n;
		logic [RW-1:0] r_n;
		logic [VW-1:0] v_r;
		logic [RW-1:0] r_r;

		assign trial = {1'b0, r_s[i]} + ONE;
		assign take  = ({2'b0, v_s[i]} >= trial);
		assign v_n   = take ? VW'({2'b0, v_s[i]} - trial) : v_s[i];
		assign r_n   = take ? RW'((r_s[i] >> 1) + ONE[RW-1:0]) : (r_s[i] >> 1);

		always_ff @(posedge clk) begin
			if (en) begin
				v_r <= v_n;
				r_r <= r_n;
			end
		end

		assign v_s[i+1] = v_r;
		assign r_s[i+1] = r_r;
	end

	assign root = r_s[rtdct_pkg::SQ_STG][rtdct_pkg::ROOT_W-1:0];

endmodule

/* hdl/rtdct_poly.sv */
module rtdct_poly (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rtdct_pkg::X_W-1:0]    x,
	output rtdct_pkg::acc_t              acc
);

	localparam int AW = rtdct_pkg::ACC_W;
	localparam int LW = 21;
	localparam int HW = AW - LW;
	localparam int XW = rtdct_pkg::X_W;

	rtdct_pkg::acc_t     acc_p [0:5];
	logic [XW-1:0]       x_p   [0:5];

	assign acc_p[0] = rtdct_pkg::POLY_Q24[0];
	assign x_p[0]   = x;

	// each horner step: split multiply, then shift and add coefficient
	for (genvar k = 1; k <= 5; k++) begin : g_step
		logic signed [HW+XW:0]   ph_s;
		logic [LW+XW-1:0]        pl_s;
		logic [XW-1:0]           xa_s;
		logic signed [AW+XW+1:0] sum;
		rtdct_pkg::acc_t         acc_r;
		logic [XW-1:0]           xb_r;

		assign sum = ((AW+XW+2)'(ph_s) <<< LW) + $signed({3'b0, pl_s});

		always_ff @(posedge clk) begin
			if (en) begin
				ph_s  <= $signed(acc_p[k-1][AW-1:LW]) * $signed({1'b0, x_p[k-1]});
				pl_s  <= acc_p[k-1][LW-1:0] * x_p[k-1];
				xa_s  <= x_p[k-1];
				acc_r <= $signed(sum[AW+XW-1:XW]) + rtdct_pkg::POLY_Q24[k];
				xb_r  <= xa_s;
			end
		end

		assign acc_p[k] = acc_r;
		assign x_p[k]   = xb_r;
	end

	assign acc = acc_p[5];

endmodule

/* hdl/rtdct_back.sv */
module rtdct_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rtdct_pkg::q_entry_t          head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rtdct_pkg::TEMP_W-1:0] temp_centideg,
	output logic                         out_of_range
);

	localparam int NV   = 30;
	localparam int NDLY = 19;

	logic en;
	logic [NV-1:0] vld_q;
	logic out_valid_q;
	rtdct_pkg::rq_t rq_s1;
	logic [rtdct_pkg::PROD_W-1:0] prod_s2;
	logic [rtdct_pkg::ARG_W-1:0]  arg_s3;
	logic signed [rtdct_pkg::PROD_W:0] arg_full;
	logic [rtdct_pkg::ROOT_W-1:0] root;
	rtdct_pkg::acc_t acc;
	rtdct_pkg::acc_t acc_dly_q [0:NDLY-1];
	logic signed [rtdct_pkg::ROOT_W+1:0] t8;
	logic signed [rtdct_pkg::ACC_W:0]    accr;
	logic signed [20:0] t_raw;
	logic [rtdct_pkg::TEMP_W-1:0] temp_q;
	logic flag_q;

	assign en  = !out_valid_q || out_ready;
	assign pop = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[NV-2:0], head.valid};
			out_valid_q <= vld_q[NV-1];
		end
	end

	// a negative argument is replaced by zero: the root path then clamps high
	assign arg_full = $signed({{(rtdct_pkg::PROD_W-rtdct_pkg::ARG_W){1'b0}}, rtdct_pkg::ARG0_Q16})
		- $signed({1'b0, prod_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			rq_s1   <= head.rq;
			prod_s2 <= rtdct_pkg::K1_PER_RQ * rq_s1;
			arg_s3  <= arg_full[rtdct_pkg::PROD_W] ? '0 : arg_full[rtdct_pkg::ARG_W-1:0];
			acc_dly_q[0] <= acc;
			for (int i = 1; i < NDLY; i++) begin
				acc_dly_q[i] <= acc_dly_q[i-1];
			end
		end
	end

	rtdct_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.arg  (arg_s3),
		.root (root)
	);

	rtdct_poly u_poly (
		.clk (clk),
		.en  (en),
		.x   (rq_s1[rtdct_pkg::X_W-1:0]),
		.acc (acc)
	);

	assign t8   = $signed({1'b0, rtdct_pkg::C0_Q8}) - $signed({2'b0, root});
	assign accr = $signed({acc_dly_q[NDLY-1][rtdct_pkg::ACC_W-1], acc_dly_q[NDLY-1]})
		+ (rtdct_pkg::ACC_W+1)'(1 << 23);

	always_comb begin
		if (!t8[rtdct_pkg::ROOT_W+1]) begin
			t_raw = 21'($signed(t8 + 29'sd128) >>> 8);
		end else begin
			t_raw = 21'(accr >>> 24);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (t_raw > rtdct_pkg::TEMP_MAX) begin
				temp_q <= rtdct_pkg::TEMP_MAX[rtdct_pkg::TEMP_W-1:0];
				flag_q <= 1'b1;
			end else if (t_raw < rtdct_pkg::TEMP_MIN) begin
				temp_q <= rtdct_pkg::TEMP_MIN[rtdct_pkg::TEMP_W-1:0];
				flag_q <= 1'b1;
			end else begin
				temp_q <= t_raw[rtdct_pkg::TEMP_W-1:0];
				flag_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign temp_centideg = temp_q;
	assign out_of_range  = flag_q;

endmodule

/* hdl/rtd_code_to_temperature_core.sv */
// throughput: one request per cycle while the output is not stalled; a 27-stage square root and a 10-stage horner
// polynomial run side by side behind a 4-entry queue
// output stall freezes the back pipeline, the queue holds up to 4 requests in all
// reset (arst_n low) empties queue and pipeline, reference register returns to 430 ohms
module rtd_code_to_temperature_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rtdct_pkg::REF_W-1:0]     cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rtdct_pkg::RAW_W-1:0]     s_axis_tdata,  // [15:0] raw_word
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rtdct_pkg::TDATA_W-1:0]   m_axis_tdata,  // [17:0] temp_centideg, rest zero
	output logic                            m_axis_tuser   // [0] out_of_range
);

	rtdct_pkg::q_entry_t push, head;
	logic full, pop;
	logic [rtdct_pkg::TEMP_W-1:0] temp;

	assign s_axis_tready = !full;

	rtdct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.raw_word  (s_axis_tdata),
		.push      (push)
	);

	rtdct_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	rtdct_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.temp_centideg (temp),
		.out_of_range  (m_axis_tuser)
	);

	assign m_axis_tdata = {{(rtdct_pkg::TDATA_W-rtdct_pkg::TEMP_W){1'b0}}, temp};

endmodule

/* hdl/rtdct_checker.sv */
module rtdct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic signed [17:0] t;
	assign t = $signed(m_axis_tdata[17:0]);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
		else $error("tdata padding not zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (t >= -18'sd25000) && (t <= 18'sd100000))
		else $error("temperature outside clamp range");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (t == 18'sd100000) || (t == -18'sd25000))
		else $error("flag raised without clamped value");

endmodule

bind rtd_code_to_temperature_core rtdct_checker u_rtdct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
